FILE: rtl/cr_pkg.sv
// ----------------------------------------------------------------------------
// cr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package cr_pkg;

    // field widths
    localparam int COORD_W    = 8;
    localparam int RADIUS_W   = 7;
    localparam int OFFSET_W   = 8;   // signed step offsets, y may reach -1
    localparam int DECISION_W = 12;
    localparam int SUM_W      = 10;

    // defaults for top level parameters
    localparam int RADIUS_MAX_DEF  = 80;
    localparam int QUEUE_DEPTH_DEF = 2;

    // results per circle never exceed this count
    localparam int MAX_RESULTS = 60;
    localparam int COUNT_W     = $clog2(MAX_RESULTS);

    // decision variable constants
    localparam logic signed [DECISION_W-1:0] DEC_INIT    = 12'sd3;
    localparam logic signed [DECISION_W-1:0] DEC_ADD_DN  = 12'sd10;
    localparam logic signed [DECISION_W-1:0] DEC_ADD_HLD = 12'sd6;

    // classified circle command handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0]                center_x;
        logic [COORD_W-1:0]                center_y;
        logic [RADIUS_W-1:0]               radius;
        logic signed [DECISION_W-1:0]      decision;
    } cmd_t;

    // engine states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } eng_state_t;

endpackage

FILE: rtl/cr_front.sv
// ----------------------------------------------------------------------------
// cr_front
// Accepts circle commands, saturates the radius and precomputes the initial
// decision value, holding the result in one register stage.
// ----------------------------------------------------------------------------
module cr_front #(
    parameter int RADIUS_MAX = cr_pkg::RADIUS_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cr_pkg::COORD_W-1:0]    s_center_x,
    input  logic [cr_pkg::COORD_W-1:0]    s_center_y,
    input  logic [cr_pkg::RADIUS_W-1:0]   s_radius,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output cr_pkg::cmd_t                  cmd
);
    import cr_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    cmd_t                  cmd_reg;
    cmd_t                  cmd_next;
    logic [RADIUS_W-1:0]   radius_sat;
    logic                  take;

    // stage is free when empty or draining this cycle
    assign s_ready = !valid_reg || cmd_ready;
    assign take    = s_valid && s_ready;

    // radius clamp and initial decision 3 - 2r
    always_comb begin
        radius_sat = (s_radius > RADIUS_W'(RADIUS_MAX)) ? RADIUS_W'(RADIUS_MAX) : s_radius;
        cmd_next.center_x = s_center_x;
        cmd_next.center_y = s_center_y;
        cmd_next.radius   = radius_sat;
        cmd_next.decision = DEC_INIT
                          - signed'({{(DECISION_W-RADIUS_W-1){1'b0}}, radius_sat, 1'b0});
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

`ifndef NO_ASSERTIONS
    // a held command stays put until the queue takes it
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !cmd_ready |=> valid_reg && $stable(cmd_reg))
        else $error("front command changed while stalled");

    // stored radius never exceeds the bound
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> cmd_reg.radius <= RADIUS_W'(RADIUS_MAX))
        else $error("front radius above bound");

    // a new beat always lands in the stage
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> valid_reg)
        else $error("front dropped an accepted beat");
`endif

endmodule

FILE: rtl/cr_queue.sv
// ----------------------------------------------------------------------------
// cr_queue
// Small command queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module cr_queue #(
    parameter int DEPTH = cr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cr_pkg::cmd_t   in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output cr_pkg::cmd_t   out_cmd
);
    import cr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    // fill count stays within depth
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue overfilled");

    // pointers agree with the fill count when empty or full
    a_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");

    // a lone push makes the queue non empty next cycle
    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> out_valid)
        else $error("queue lost a push");
`endif

endmodule

FILE: rtl/cr_engine.sv
// ----------------------------------------------------------------------------
// cr_engine
// Back end: walks the midpoint decision iteration one octant step per cycle
// while m_ready does not stall it, and drives the registered result channel.
// ----------------------------------------------------------------------------
module cr_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  cr_pkg::cmd_t                      cmd,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cx_plus_x,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cx_minus_x,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cx_plus_y,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cx_minus_y,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cy_plus_x,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cy_minus_x,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cy_plus_y,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cy_minus_y,
    output logic                              m_last_step
);
    import cr_pkg::*;

    eng_state_t                     state_reg;
    eng_state_t                     state_next;
    logic signed [OFFSET_W-1:0]     x_reg;
    logic signed [OFFSET_W-1:0]     x_next;
    logic signed [OFFSET_W-1:0]     y_reg;
    logic signed [OFFSET_W-1:0]     y_next;
    logic signed [DECISION_W-1:0]   d_reg;
    logic signed [DECISION_W-1:0]   d_next;
    logic [COORD_W-1:0]             cx_reg;
    logic [COORD_W-1:0]             cy_reg;
    logic [COUNT_W-1:0]             cnt_reg;
    logic [COUNT_W-1:0]             cnt_next;
    logic                           load;
    logic                           emit;
    logic                           last;
    logic                           out_free;
    logic signed [DECISION_W-1:0]   xe;
    logic signed [DECISION_W-1:0]   ye;
    logic signed [OFFSET_W-1:0]     x_inc;
    logic signed [OFFSET_W-1:0]     y_dec;
    logic signed [SUM_W-1:0]        cx10;
    logic signed [SUM_W-1:0]        cy10;
    logic signed [SUM_W-1:0]        x10;
    logic signed [SUM_W-1:0]        y10;

    // output beat register
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic signed [SUM_W-1:0]        cxpx_reg;
    logic signed [SUM_W-1:0]        cxmx_reg;
    logic signed [SUM_W-1:0]        cxpy_reg;
    logic signed [SUM_W-1:0]        cxmy_reg;
    logic signed [SUM_W-1:0]        cypx_reg;
    logic signed [SUM_W-1:0]        cymx_reg;
    logic signed [SUM_W-1:0]        cypy_reg;
    logic signed [SUM_W-1:0]        cymy_reg;
    logic                           last_reg;

    assign out_free = !m_valid_reg || m_ready;
    // loop ends when y drops below x or the result cap is hit
    assign last     = (y_reg < x_reg) || (cnt_reg == COUNT_W'(MAX_RESULTS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free && last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        cmd_ready = 1'b0;
        emit      = 1'b0;
        case (state_reg)
            ST_IDLE: cmd_ready = 1'b1;
            ST_RUN:  emit      = out_free;
            default: begin
                cmd_ready = 1'b0;
                emit      = 1'b0;
            end
        endcase
    end

    assign load = cmd_ready && cmd_valid;

    // one midpoint step
    always_comb begin
        x_inc = x_reg + OFFSET_W'(1);
        y_dec = y_reg - OFFSET_W'(1);
        xe    = DECISION_W'(x_inc);
        ye    = DECISION_W'(y_dec);
        x_next   = x_reg;
        y_next   = y_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        if (load) begin
            x_next   = '0;
            y_next   = signed'({1'b0, cmd.radius});
            d_next   = cmd.decision;
            cnt_next = '0;
        end else if (emit) begin
            x_next   = x_inc;
            cnt_next = last ? cnt_reg : cnt_reg + 1'b1;
            if (d_reg > 0) begin
                y_next = y_dec;
                d_next = d_reg + ((xe - ye) <<< 2) + DEC_ADD_DN;
            end else begin
                d_next = d_reg + (xe <<< 2) + DEC_ADD_HLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // iteration payload
    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        d_reg <= d_next;
        if (load) begin
            cx_reg <= cmd.center_x;
            cy_reg <= cmd.center_y;
        end
    end

    // symmetric sums for the current offsets
    assign cx10 = signed'({{(SUM_W-COORD_W){1'b0}}, cx_reg});
    assign cy10 = signed'({{(SUM_W-COORD_W){1'b0}}, cy_reg});
    assign x10  = SUM_W'(x_reg);
    assign y10  = SUM_W'(y_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            cxpx_reg <= cx10 + x10;
            cxmx_reg <= cx10 - x10;
            cxpy_reg <= cx10 + y10;
            cxmy_reg <= cx10 - y10;
            cypx_reg <= cy10 + x10;
            cymx_reg <= cy10 - x10;
            cypy_reg <= cy10 + y10;
            cymy_reg <= cy10 - y10;
            last_reg <= last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cx_plus_x  = cxpx_reg;
    assign m_cx_minus_x = cxmx_reg;
    assign m_cx_plus_y  = cxpy_reg;
    assign m_cx_minus_y = cxmy_reg;
    assign m_cy_plus_x  = cypx_reg;
    assign m_cy_minus_x = cymx_reg;
    assign m_cy_plus_y  = cypy_reg;
    assign m_cy_minus_y = cymy_reg;
    assign m_last_step  = last_reg;

`ifndef NO_ASSERTIONS
    // step count stays under the result cap
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < COUNT_W'(MAX_RESULTS))
        else $error("engine step count over cap");

    // a loaded command starts a walk
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> state_reg == ST_RUN && cnt_reg == '0 && x_reg == '0)
        else $error("engine did not start walk");

    // the final step returns the engine to idle
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && last |=> state_reg == ST_IDLE && m_valid && m_last_step)
        else $error("engine missed end of circle");

    // x only grows during a walk
    a_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !last |=> x_reg == $past(x_reg) + OFFSET_W'(1))
        else $error("engine x offset did not advance");
`endif

endmodule

FILE: rtl/circle_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_rasterizer
// Midpoint circle generator: one command in, one beat per octant step out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel s_*: one beat carries a circle command (center_x, center_y,
//   radius). A radius above RADIUS_MAX is clamped to it.
//   Result channel m_*: one beat per octant step, starting at offsets (0, r),
//   with the center plus/minus x and y sums for the eight symmetric pixels.
//   m_last_step marks the final beat of a circle; a circle has at most 60.
//   The first result beat of a command is registered after it has passed
//   the front stage, the queue and the engine load. The back end emits
//   one beat per cycle while m_ready does not stall it, and returns to
//   idle to load each command from the queue between circles.
//   The front stage and a QUEUE_DEPTH command queue keep taking commands
//   while the back end walks a circle.
//   A stall on m_ready holds the current beat and freezes the walk; the
//   front keeps accepting until the queue fills.
//   Reset (aresetn low, synchronous) empties the queue and returns the
//   engine to idle with no beat pending.
// ----------------------------------------------------------------------------
module circle_rasterizer #(
    parameter int RADIUS_MAX  = cr_pkg::RADIUS_MAX_DEF,
    parameter int QUEUE_DEPTH = cr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cr_pkg::COORD_W-1:0]        s_center_x,
    input  logic [cr_pkg::COORD_W-1:0]        s_center_y,
    input  logic [cr_pkg::RADIUS_W-1:0]       s_radius,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cx_plus_x,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cx_minus_x,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cx_plus_y,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cx_minus_y,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cy_plus_x,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cy_minus_x,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cy_plus_y,
    output logic signed [cr_pkg::SUM_W-1:0]   m_cy_minus_y,
    output logic                              m_last_step
);
    import cr_pkg::*;

    logic   f_valid;
    logic   f_ready;
    cmd_t   f_cmd;
    logic   q_valid;
    logic   q_ready;
    cmd_t   q_cmd;

    // accept and classify
    cr_front #(
        .RADIUS_MAX (RADIUS_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_radius   (s_radius),
        .cmd_valid  (f_valid),
        .cmd_ready  (f_ready),
        .cmd        (f_cmd)
    );

    // decoupling queue
    cr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // step engine
    cr_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (q_valid),
        .cmd_ready    (q_ready),
        .cmd          (q_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cx_plus_x  (m_cx_plus_x),
        .m_cx_minus_x (m_cx_minus_x),
        .m_cx_plus_y  (m_cx_plus_y),
        .m_cx_minus_y (m_cx_minus_y),
        .m_cy_plus_x  (m_cy_plus_x),
        .m_cy_minus_x (m_cy_minus_x),
        .m_cy_plus_y  (m_cy_plus_y),
        .m_cy_minus_y (m_cy_minus_y),
        .m_last_step  (m_last_step)
    );

endmodule
